### rtl/acsa_pkg.sv
// Shared constants and types for the aligned contiguous slot allocator.
package acsa_pkg;

   // Slot window geometry
   localparam int SLOT_COUNT      = 512;
   localparam int SLOT_W          = $clog2(SLOT_COUNT);
   localparam int SLOT_SIZE_SHIFT = 30;

   // Request and response field widths
   localparam int LEN_W        = 10;
   localparam int FIRST_SLOT_W = 9;
   localparam int ADDR_W       = 64;

   localparam logic [ADDR_W-1:0] BASE_RESET = 64'hFFFF_C000_0000_0000;

   // Bitmap memory layout: rows of up to 64 slots, always at least two rows
   localparam int ROW_BITS  = (SLOT_W > 6) ? 6 : SLOT_W - 1;
   localparam int ROW_W     = 1 << ROW_BITS;
   localparam int ROW_COUNT = SLOT_COUNT >> ROW_BITS;
   localparam int ROW_IDX_W = SLOT_W - ROW_BITS;

   // Width for candidate start arithmetic (slot + alignment + length)
   localparam int JMP_W = ((SLOT_W > LEN_W) ? SLOT_W : LEN_W) + 2;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_FETCH   = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_MARK_RD = 6'b001000,
      ST_MARK_WR = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

endpackage

### rtl/acsa_ram.sv
// Generic single-port synchronous RAM with registered read data.
module acsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/aligned_contiguous_slot_allocator.sv
// Top level: first-fit aligned run allocator over a slot-used bitmap in RAM.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   request  | req_valid / req_ready  | req_run_length, req_alignment
//   response | rsp_valid / rsp_ready  | rsp_granted, rsp_first_slot, rsp_virt_address
//   csr      | csr_wr_en              | csr_wr_data (window base address)
//
// One request at a time. A zero or oversized run length goes straight from accept to the finish state.
// Otherwise the scan pointer steps or jumps through the slots (it only moves forward), one
// bitmap row is read each time the pointer enters a new row, and each marked row is read
// and then written back.
// Reset clears the per-row valid flags, so the bitmap reads as all free at once.
// The response register holds while rsp_ready is low; the next request is still taken
// and searched, and waits in the finish state until the response register frees.
module aligned_contiguous_slot_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [acsa_pkg::LEN_W-1:0]         req_run_length,
   input  logic [acsa_pkg::LEN_W-1:0]         req_alignment,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_granted,
   output logic [acsa_pkg::FIRST_SLOT_W-1:0]  rsp_first_slot,
   output logic [acsa_pkg::ADDR_W-1:0]        rsp_virt_address,
   input  logic                               csr_wr_en,
   input  logic [acsa_pkg::ADDR_W-1:0]        csr_wr_data
);

   // Control state
   acsa_pkg::state_type                 state_ff, state_in;
   logic [acsa_pkg::ROW_COUNT-1:0]      rowval_ff, rowval_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [acsa_pkg::ADDR_W-1:0]         base_ff, base_in;

   // Request working registers
   logic [acsa_pkg::LEN_W-1:0]          len_ff, len_in;
   logic [acsa_pkg::LEN_W-1:0]          align_ff, align_in;
   logic [acsa_pkg::SLOT_W-1:0]         start_ff, start_in;
   logic [acsa_pkg::SLOT_W-1:0]         ptr_ff, ptr_in;
   logic [acsa_pkg::LEN_W-1:0]          phase_ff, phase_in;
   logic [acsa_pkg::LEN_W-1:0]          cnt_ff, cnt_in;
   logic [acsa_pkg::ROW_IDX_W-1:0]      row_ff, row_in;
   logic                                rowv_ff, rowv_in;
   logic                                grant_ff, grant_in;

   // Response payload registers
   logic                                rsp_granted_ff, rsp_granted_in;
   logic [acsa_pkg::FIRST_SLOT_W-1:0]   rsp_first_slot_ff, rsp_first_slot_in;
   logic [acsa_pkg::ADDR_W-1:0]         rsp_virt_address_ff, rsp_virt_address_in;

   // Bitmap RAM port
   logic                                ram_rd_en;
   logic                                ram_wr_en;
   logic [acsa_pkg::ROW_IDX_W-1:0]      ram_addr;
   logic [acsa_pkg::ROW_W-1:0]          ram_wr_data;
   logic [acsa_pkg::ROW_W-1:0]          ram_rd_data;

   // Scan helpers
   logic                                cur_used;
   logic [acsa_pkg::JMP_W-1:0]          jump_slot;
   logic                                jump_fails;
   logic [acsa_pkg::LEN_W-1:0]          cnt_next;
   logic [acsa_pkg::LEN_W-1:0]          phase_next;
   logic [acsa_pkg::SLOT_W-1:0]         ptr_next;
   logic [acsa_pkg::SLOT_W-1:0]         end_slot;
   logic [acsa_pkg::ROW_W-1:0]          mark_mask;
   logic [acsa_pkg::ROW_W-1:0]          row_word;

   acsa_ram #(
      .WIDTH(acsa_pkg::ROW_W),
      .DEPTH(acsa_pkg::ROW_COUNT)
   ) u_bitmap (
      .clock  (clock),
      .rd_en  (ram_rd_en),
      .wr_en  (ram_wr_en),
      .addr   (ram_addr),
      .wr_data(ram_wr_data),
      .rd_data(ram_rd_data)
   );

   // Fetched row, with never-written rows reading as free
   assign row_word = ram_rd_data & {acsa_pkg::ROW_W{rowv_ff}};
   assign cur_used = row_word[ptr_ff[acsa_pkg::ROW_BITS-1:0]];

   // Next aligned candidate past the current slot: ptr - (ptr mod align) + align
   assign jump_slot  = acsa_pkg::JMP_W'(ptr_ff) - acsa_pkg::JMP_W'(phase_ff)
                     + acsa_pkg::JMP_W'(align_ff);
   assign jump_fails = (jump_slot + acsa_pkg::JMP_W'(len_ff))
                     > acsa_pkg::JMP_W'(acsa_pkg::SLOT_COUNT);

   assign cnt_next   = cnt_ff + 1'b1;
   assign phase_next = ((phase_ff + 1'b1) == align_ff) ? '0 : phase_ff + 1'b1;
   assign ptr_next   = ptr_ff + 1'b1;
   assign end_slot   = acsa_pkg::SLOT_W'(acsa_pkg::JMP_W'(start_ff)
                     + acsa_pkg::JMP_W'(len_ff) - 1'b1);

   // Bits of the current marking row that fall inside the granted run
   always_comb begin
      logic [acsa_pkg::SLOT_W-1:0] mark_slot;
      mark_slot = '0;
      for (int i = 0; i < acsa_pkg::ROW_W; i++) begin
         mark_slot    = {row_ff, acsa_pkg::ROW_BITS'(i)};
         mark_mask[i] = (mark_slot >= start_ff) && (mark_slot <= end_slot);
      end
   end

   assign req_ready = (state_ff == acsa_pkg::ST_IDLE);

   // Sequencer: scan, then read-modify-write the marked rows
   always_comb begin
      state_in            = state_ff;
      rowval_in           = rowval_ff;
      rsp_valid_in        = rsp_valid_ff;
      base_in             = csr_wr_en ? csr_wr_data : base_ff;
      len_in              = len_ff;
      align_in            = align_ff;
      start_in            = start_ff;
      ptr_in              = ptr_ff;
      phase_in            = phase_ff;
      cnt_in              = cnt_ff;
      row_in              = row_ff;
      rowv_in             = rowv_ff;
      grant_in            = grant_ff;
      rsp_granted_in      = rsp_granted_ff;
      rsp_first_slot_in   = rsp_first_slot_ff;
      rsp_virt_address_in = rsp_virt_address_ff;
      ram_rd_en           = 1'b0;
      ram_wr_en           = 1'b0;
      ram_addr            = ptr_ff[acsa_pkg::SLOT_W-1:acsa_pkg::ROW_BITS];
      ram_wr_data         = row_word | mark_mask;

      // Response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         acsa_pkg::ST_IDLE: begin
            if (req_valid) begin
               len_in   = req_run_length;
               align_in = (req_alignment == '0) ? acsa_pkg::LEN_W'(1) : req_alignment;
               start_in = '0;
               ptr_in   = '0;
               phase_in = '0;
               cnt_in   = '0;
               if (req_run_length == '0) begin
                  grant_in = 1'b1;
                  state_in = acsa_pkg::ST_DONE;
               end else if (acsa_pkg::JMP_W'(req_run_length)
                            > acsa_pkg::JMP_W'(acsa_pkg::SLOT_COUNT)) begin
                  grant_in = 1'b0;
                  state_in = acsa_pkg::ST_DONE;
               end else begin
                  state_in = acsa_pkg::ST_FETCH;
               end
            end
         end
         acsa_pkg::ST_FETCH: begin
            ram_rd_en = 1'b1;
            rowv_in   = rowval_ff[ptr_ff[acsa_pkg::SLOT_W-1:acsa_pkg::ROW_BITS]];
            state_in  = acsa_pkg::ST_SCAN;
         end
         acsa_pkg::ST_SCAN: begin
            if (cur_used) begin
               // Every candidate up to this slot covers it: skip to the next aligned one
               if (jump_fails) begin
                  grant_in = 1'b0;
                  state_in = acsa_pkg::ST_DONE;
               end else begin
                  start_in = acsa_pkg::SLOT_W'(jump_slot);
                  ptr_in   = acsa_pkg::SLOT_W'(jump_slot);
                  phase_in = '0;
                  cnt_in   = '0;
                  if (acsa_pkg::SLOT_W'(jump_slot) >> acsa_pkg::ROW_BITS
                      != ptr_ff >> acsa_pkg::ROW_BITS) begin
                     state_in = acsa_pkg::ST_FETCH;
                  end
               end
            end else if (cnt_next == len_ff) begin
               row_in   = start_ff[acsa_pkg::SLOT_W-1:acsa_pkg::ROW_BITS];
               state_in = acsa_pkg::ST_MARK_RD;
            end else begin
               cnt_in   = cnt_next;
               ptr_in   = ptr_next;
               phase_in = phase_next;
               if (ptr_next[acsa_pkg::ROW_BITS-1:0] == '0) begin
                  state_in = acsa_pkg::ST_FETCH;
               end
            end
         end
         acsa_pkg::ST_MARK_RD: begin
            ram_rd_en = 1'b1;
            ram_addr  = row_ff;
            rowv_in   = rowval_ff[row_ff];
            state_in  = acsa_pkg::ST_MARK_WR;
         end
         acsa_pkg::ST_MARK_WR: begin
            ram_wr_en         = 1'b1;
            ram_addr          = row_ff;
            rowval_in[row_ff] = 1'b1;
            if (row_ff == end_slot[acsa_pkg::SLOT_W-1:acsa_pkg::ROW_BITS]) begin
               grant_in = 1'b1;
               state_in = acsa_pkg::ST_DONE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = acsa_pkg::ST_MARK_RD;
            end
         end
         acsa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_granted_in    = grant_ff;
               rsp_first_slot_in = grant_ff ? acsa_pkg::FIRST_SLOT_W'(start_ff) : '0;
               rsp_virt_address_in = grant_ff
                  ? base_ff + (acsa_pkg::ADDR_W'(start_ff) << acsa_pkg::SLOT_SIZE_SHIFT)
                  : '0;
               state_in = acsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = acsa_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acsa_pkg::ST_IDLE;
         rowval_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= acsa_pkg::BASE_RESET;
      end else begin
         state_ff     <= state_in;
         rowval_ff    <= rowval_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      len_ff              <= len_in;
      align_ff            <= align_in;
      start_ff            <= start_in;
      ptr_ff              <= ptr_in;
      phase_ff            <= phase_in;
      cnt_ff              <= cnt_in;
      row_ff              <= row_in;
      rowv_ff             <= rowv_in;
      grant_ff            <= grant_in;
      rsp_granted_ff      <= rsp_granted_in;
      rsp_first_slot_ff   <= rsp_first_slot_in;
      rsp_virt_address_ff <= rsp_virt_address_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_first_slot   = rsp_first_slot_ff;
   assign rsp_virt_address = rsp_virt_address_ff;

   // Run count always equals pointer distance from the candidate start
   a_scan_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsa_pkg::ST_SCAN) |->
         (acsa_pkg::JMP_W'(ptr_ff) - acsa_pkg::JMP_W'(start_ff)
          == acsa_pkg::JMP_W'(cnt_ff)))
      else $error("scan pointer and run count out of step");

   // A scan never sits on a run already long enough
   a_scan_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsa_pkg::ST_SCAN) |-> (cnt_ff < len_ff))
      else $error("scan continued past a complete run");

   // Single RAM port: no read and write together
   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_rd_en && ram_wr_en))
      else $error("bitmap RAM read and write in the same cycle");

   // A pending response is never overwritten by the next one
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsa_pkg::ST_DONE && rsp_valid_ff && !rsp_ready) |=>
         (state_ff == acsa_pkg::ST_DONE))
      else $error("finished request left while response was stalled");

   // Failed requests report zero slot and address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted_ff) |->
         (rsp_virt_address_ff == '0 && rsp_first_slot_ff == '0))
      else $error("failed response carries nonzero slot or address");

endmodule

### tb/tb.sv
// Self-checking testbench for the aligned contiguous slot allocator.
`timescale 1ns / 100ps

module tb;

   // One response as the block reports it
   typedef struct packed {
      logic                              granted;
      logic [acsa_pkg::FIRST_SLOT_W-1:0] first_slot;
      logic [acsa_pkg::ADDR_W-1:0]       virt_address;
   } grant_result_type;

   // Directed stimulus row: optional base write, request, optional fixed answer
   typedef struct packed {
      logic                        set_base;
      logic [acsa_pkg::ADDR_W-1:0] base;
      logic [acsa_pkg::LEN_W-1:0]  run_length;
      logic [acsa_pkg::LEN_W-1:0]  alignment;
      logic                        fixed;
      grant_result_type            answer;
   } directed_row_type;

   localparam grant_result_type NO_GRANT    = '0;
   localparam int               STALL_LIMIT = 20000;
   localparam int               HOLD_CYCLES = 3000;
   localparam int               PHASE_ITEMS = 330;
   localparam int               DIR_ROWS    = 21;

   localparam logic [acsa_pkg::ADDR_W-1:0] ALL_ONES = '1;
   localparam logic [acsa_pkg::ADDR_W-1:0] STRIPES  = 64'hAAAA_5555_AAAA_5555;
   localparam logic [acsa_pkg::ADDR_W-1:0] BASE_RST = acsa_pkg::BASE_RESET;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [acsa_pkg::LEN_W-1:0]        req_run_length = '0;
   logic [acsa_pkg::LEN_W-1:0]        req_alignment = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_granted;
   logic [acsa_pkg::FIRST_SLOT_W-1:0] rsp_first_slot;
   logic [acsa_pkg::ADDR_W-1:0]       rsp_virt_address;
   logic                              csr_wr_en = 1'b0;
   logic [acsa_pkg::ADDR_W-1:0]       csr_wr_data = '0;

   // Predictor state: slot-used bitmap and the window base
   bit [acsa_pkg::SLOT_COUNT-1:0]  slot_taken = '0;
   logic [acsa_pkg::ADDR_W-1:0]    window_base = acsa_pkg::BASE_RESET;

   grant_result_type grant_expect_q[$];
   int               mismatch_count = 0;
   int               req_idle_pct = 22;
   int               rsp_idle_pct = 67;
   int               rsp_hold_left = 0;

   // Directed requests; fixed answers only where obvious
   directed_row_type dir_table [DIR_ROWS] = '{
      // zero length right after reset: slot 0 at the reset base
      '{1'b0, 64'h0, 10'd0,    10'd0,    1'b1, '{1'b1, 9'd0, BASE_RST}},
      // runs longer than the window
      '{1'b0, 64'h0, 10'd513,  10'd1,    1'b1, NO_GRANT},
      '{1'b0, 64'h0, 10'd1023, 10'd1023, 1'b1, NO_GRANT},
      // zero alignment acts as one
      '{1'b0, 64'h0, 10'd1,    10'd0,    1'b1, '{1'b1, 9'd0, BASE_RST}},
      '{1'b0, 64'h0, 10'd1,    10'd0,    1'b1, '{1'b1, 9'd1, 64'hFFFF_C000_4000_0000}},
      '{1'b0, 64'h0, 10'd2,    10'd4,    1'b0, NO_GRANT},
      // only candidate is slot 0, already used
      '{1'b0, 64'h0, 10'd3,    10'd512,  1'b1, NO_GRANT},
      '{1'b0, 64'h0, 10'd512,  10'd1,    1'b1, NO_GRANT},
      // last slot
      '{1'b0, 64'h0, 10'd1,    10'd511,  1'b0, NO_GRANT},
      '{1'b0, 64'h0, 10'd8,    10'd8,    1'b0, NO_GRANT},
      // base of zero
      '{1'b1, 64'h0, 10'd0,    10'd5,    1'b1, '{1'b1, 9'd0, 64'h0}},
      '{1'b0, 64'h0, 10'd1,    10'd2,    1'b0, NO_GRANT},
      // all-ones base: address wraps
      '{1'b1, ALL_ONES, 10'd1, 10'd0,    1'b0, NO_GRANT},
      '{1'b0, 64'h0, 10'd0,    10'd1023, 1'b1, '{1'b1, 9'd0, ALL_ONES}},
      '{1'b0, 64'h0, 10'd64,   10'd64,   1'b0, NO_GRANT},
      '{1'b1, STRIPES, 10'd256, 10'd256, 1'b0, NO_GRANT},
      '{1'b0, 64'h0, 10'd32,   10'd128,  1'b0, NO_GRANT},
      '{1'b1, BASE_RST, 10'd1, 10'd1,    1'b0, NO_GRANT},
      '{1'b0, 64'h0, 10'd600,  10'd0,    1'b1, NO_GRANT},
      '{1'b0, 64'h0, 10'd5,    10'd3,    1'b0, NO_GRANT},
      '{1'b0, 64'h0, 10'd1,    10'd1,    1'b0, NO_GRANT}
   };

   aligned_contiguous_slot_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_run_length   (req_run_length),
      .req_alignment    (req_alignment),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_first_slot   (rsp_first_slot),
      .rsp_virt_address (rsp_virt_address),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   // First-fit search over the bitmap; marks the run on a grant
   function automatic grant_result_type predict_grant(
      input logic [acsa_pkg::LEN_W-1:0] run_length,
      input logic [acsa_pkg::LEN_W-1:0] alignment);
      grant_result_type result;
      int unsigned      step;
      int unsigned      start;
      int unsigned      k;
      bit               fits;
      result = NO_GRANT;
      step = (alignment == 0) ? 1 : alignment;
      for (start = 0; start + run_length <= acsa_pkg::SLOT_COUNT; start += step) begin
         fits = 1'b1;
         for (k = 0; k < run_length; k++) begin
            if (slot_taken[start + k]) begin
               fits = 1'b0;
               break;
            end
         end
         if (fits) begin
            for (k = 0; k < run_length; k++)
               slot_taken[start + k] = 1'b1;
            result.granted      = 1'b1;
            result.first_slot   = start[acsa_pkg::FIRST_SLOT_W-1:0];
            result.virt_address = window_base
                                + (64'(start) << acsa_pkg::SLOT_SIZE_SHIFT);
            return result;
         end
      end
      return result;
   endfunction

   // Offer one request, wait for accept, queue its expected response
   task automatic send_request(input logic [acsa_pkg::LEN_W-1:0] run_length,
                               input logic [acsa_pkg::LEN_W-1:0] alignment,
                               input logic fixed, input grant_result_type answer);
      grant_result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_run_length <= run_length;
      req_alignment  <= alignment;
      do @(posedge clock); while (!req_ready);
      predicted = predict_grant(run_length, alignment);
      grant_expect_q.push_back(fixed ? answer : predicted);
   endtask

   // Base writes only with no request in flight
   task automatic write_base(input logic [acsa_pkg::ADDR_W-1:0] base);
      req_valid <= 1'b0;
      while (grant_expect_q.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      window_base = base;
   endtask

   // Response side: check accepted responses, drive ready
   initial begin : response_side
      grant_result_type want;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (grant_expect_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = grant_expect_q.pop_front();
               if (rsp_granted !== want.granted) begin
                  $error("granted: expected %0d, actual %0d", want.granted, rsp_granted);
                  mismatch_count++;
               end
               if (rsp_first_slot !== want.first_slot) begin
                  $error("first_slot: expected %0d, actual %0d",
                         want.first_slot, rsp_first_slot);
                  mismatch_count++;
               end
               if (rsp_virt_address !== want.virt_address) begin
                  $error("virt_address: expected %h, actual %h",
                         want.virt_address, rsp_virt_address);
                  mismatch_count++;
               end
            end
         end
         // long hold-off to back up the request side
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Ends the run if neither channel moves for too long
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("FAILURE");
      $finish;
   end

   // Main stimulus
   initial begin : stimulus
      int                         phase;
      int                         sel;
      logic [acsa_pkg::LEN_W-1:0] run_length;
      logic [acsa_pkg::LEN_W-1:0] alignment;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_table[i]) begin
         if (dir_table[i].set_base)
            write_base(dir_table[i].base);
         send_request(dir_table[i].run_length, dir_table[i].alignment,
                      dir_table[i].fixed, dir_table[i].answer);
      end

      // random requests in three idling phases
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 22;
               rsp_idle_pct = 67;
               write_base({$urandom, $urandom});
            end
            1: begin
               req_idle_pct = 67;
               rsp_idle_pct = 22;
               write_base(ALL_ONES);
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               write_base({$urandom, $urandom});
               rsp_hold_left = HOLD_CYCLES;
            end
         endcase
         repeat (PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 10) begin
               run_length = '0;
               alignment  = acsa_pkg::LEN_W'($urandom);
            end else if (sel < 20) begin
               run_length = acsa_pkg::LEN_W'($urandom);
               alignment  = acsa_pkg::LEN_W'($urandom);
            end else if (sel < 80) begin
               // short runs, half with coarse alignment to keep space spread out
               run_length = acsa_pkg::LEN_W'($urandom_range(1, 4));
               alignment  = $urandom_range(1) ? acsa_pkg::LEN_W'($urandom_range(0, 8))
                                              : acsa_pkg::LEN_W'($urandom);
            end else begin
               run_length = acsa_pkg::LEN_W'($urandom_range(5, 64));
               alignment  = acsa_pkg::LEN_W'($urandom_range(0, 64));
            end
            send_request(run_length, alignment, 1'b0, NO_GRANT);
         end
      end

      // drain, then watch for stray responses before reporting
      req_valid <= 1'b0;
      while (grant_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
